/* hdl/stli_pkg.sv */
// Shared types and constants for the sorted table linear interpolation unit.
`default_nettype none

package stli_pkg;

	// Item kind carried on the input tuser.
	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	// One table entry; the angle sits in the low half.
	typedef struct packed {
		logic signed [15:0] lift;
		logic signed [15:0] angle;
	} entry_t;

	// Lift returned when a query cannot be answered (-1.0 in Q4.12).
	localparam logic signed [15:0] NOT_FOUND_LIFT = 16'shF000;

	// Number of quotient bits produced by the divider.
	localparam int unsigned DIV_STEPS = 32;

endpackage

`default_nettype wire

/* hdl/stli_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module stli_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire                             clk,
	input  wire                             we,
	input  wire  [$clog2(DEPTH)-1:0]        waddr,
	input  wire  [WIDTH-1:0]                wdata,
	input  wire                             re,
	input  wire  [$clog2(DEPTH)-1:0]        raddr,
	output logic [WIDTH-1:0]                rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/sorted_table_linear_interpolation_unit.sv */
// Sorted angle/lift table with stable insert and piecewise linear interpolation lookup.
//
// The unit holds up to TABLE_DEPTH (angle Q8.8, lift Q4.12) pairs in one RAM, kept in
// ascending angle order. A load transfer (tuser = 0) inserts its pair after all stored
// pairs with an equal or smaller angle, moving larger entries up one place; a full
// table refuses the load with status 2. A query transfer (tuser = 1) walks the table
// from the bottom: at an endpoint it returns the lift of the last entry with that
// angle, at a stored angle inside the range the lift of the first such entry, and
// elsewhere strictly inside the range it interpolates between the neighbors; outside
// the range or on an empty table it returns -1.0 with status 1. Loads return zero.
// One item is in flight at a time. A load passes a read state and a check state for
// each entry it moves up, then writes the pair; a query passes the same two states for
// each entry scanned. A load on a full table or a query on an empty one goes straight to
// the hand-off. An interpolating query then runs a multiply, an absolute value, the
// one-bit-per-cycle restoring divider and a final add. The single read port of the table
// RAM, with its registered read, is why each entry takes a read and a check state. A
// finished result sits in the output register, so the next item is taken while it waits.
`default_nettype none

module sorted_table_linear_interpolation_unit
	import stli_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [15:0] angle, [31:16] lift
	input  wire         s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata    // [15:0] value, [17:16] status, [23:18] zero
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned SW = $clog2(DIV_STEPS);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_CHK,
		ST_Q_RD,
		ST_Q_CHK,
		ST_MUL,
		ST_ABS,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic                 kind_q;
	logic signed [15:0]   angle_q;
	logic signed [15:0]   lift_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic                 scan_eq_q;
	logic                 run_at_zero_q;
	logic signed [15:0]   prev_angle_q;
	logic signed [15:0]   prev_lift_q;
	logic signed [15:0]   first_lift_q;
	logic [15:0]          dx_q;
	logic signed [16:0]   dl_q;
	logic [15:0]          den_q;
	logic signed [33:0]   prod_q;
	logic                 neg_q;
	logic [31:0]          quo_q;
	logic [15:0]          rem_q;
	logic [SW-1:0]        step_q;
	logic signed [15:0]   res_value_q;
	status_t              res_status_q;
	logic                 m_tvalid_q;
	logic [23:0]          m_tdata_q;

	entry_t               rd_entry;
	entry_t               new_entry;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	entry_t               ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [CW-1:0]        idx_m1;
	logic [CW-1:0]        idx_p1;
	logic                 rd_gt;
	logic                 rd_eq;
	logic signed [16:0]   dx_full;
	logic signed [16:0]   den_full;
	logic signed [16:0]   dl_full;
	logic signed [33:0]   prod_mag;
	logic [16:0]          div_shift;
	logic [16:0]          div_diff;
	logic                 div_take;
	logic signed [17:0]   q_signed;
	logic signed [17:0]   interp_sum;
	logic                 in_xfer;

	assign in_xfer   = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign new_entry = '{lift: lift_q, angle: angle_q};
	assign idx_m1 = idx_q - CW'(1);
	assign idx_p1 = idx_q + CW'(1);

	// Compare the entry just read against the item angle.
	assign rd_gt = $signed(rd_entry.angle) > angle_q;
	assign rd_eq = $signed(rd_entry.angle) == angle_q;

	// Differences for the interpolation, taken against the entry below: the query angle and the entry read.
	assign dx_full  = 17'(angle_q) - 17'(prev_angle_q);
	assign den_full = 17'(rd_entry.angle) - 17'(prev_angle_q);
	assign dl_full  = 17'(rd_entry.lift) - 17'(prev_lift_q);
	assign prod_mag = prod_q[33] ? -prod_q : prod_q;

	// Restoring divider step: one quotient bit per cycle.
	assign div_shift = {rem_q, quo_q[31]};
	assign div_diff  = div_shift - {1'b0, den_q};
	assign div_take  = !div_diff[16];

	// Apply the quotient sign and add the lower lift.
	assign q_signed   = neg_q ? -$signed({2'b00, quo_q[15:0]}) : $signed({2'b00, quo_q[15:0]});
	assign interp_sum = 18'(prev_lift_q) + q_signed;

	// Table RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = new_entry;
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			ST_LD_RD: begin
				if (idx_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = idx_m1[AW-1:0];
				end
			end
			ST_LD_CHK: begin
				ram_we    = 1'b1;
				ram_wdata = rd_gt ? rd_entry : new_entry;
			end
			ST_Q_RD: begin
				ram_re = (idx_q != count_q);
			end
			default: begin
			end
		endcase
	end

	stli_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_entry)
	);

	// Sequencer for insert, scan, interpolation and result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// A result taken outside the hand-off state frees the output register.
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						kind_q        <= s_tuser;
						angle_q       <= s_tdata[15:0];
						lift_q        <= s_tdata[31:16];
						scan_eq_q     <= 1'b0;
						run_at_zero_q <= 1'b0;
						if (s_tuser == KIND_LOAD) begin
							if (count_q >= CW'(TABLE_DEPTH)) begin
								res_value_q  <= '0;
								res_status_q <= STATUS_FULL;
								state_q      <= ST_OUT;
							end else begin
								idx_q   <= count_q;
								state_q <= ST_LD_RD;
							end
						end else if (count_q == '0) begin
							res_value_q  <= NOT_FOUND_LIFT;
							res_status_q <= STATUS_MISS;
							state_q      <= ST_OUT;
						end else begin
							idx_q   <= '0;
							state_q <= ST_Q_RD;
						end
					end
				end
				ST_LD_RD: begin
					if (idx_q == '0) begin
						count_q      <= count_q + CW'(1);
						res_value_q  <= '0;
						res_status_q <= STATUS_OK;
						state_q      <= ST_OUT;
					end else begin
						state_q <= ST_LD_CHK;
					end
				end
				ST_LD_CHK: begin
					if (rd_gt) begin
						idx_q   <= idx_m1;
						state_q <= ST_LD_RD;
					end else begin
						count_q      <= count_q + CW'(1);
						res_value_q  <= '0;
						res_status_q <= STATUS_OK;
						state_q      <= ST_OUT;
					end
				end
				ST_Q_RD: begin
					if (idx_q == count_q) begin
						// Ran off the top: either the angle equals the last one or lies above it.
						res_value_q  <= scan_eq_q ? prev_lift_q : NOT_FOUND_LIFT;
						res_status_q <= scan_eq_q ? STATUS_OK : STATUS_MISS;
						state_q      <= ST_OUT;
					end else begin
						state_q <= ST_Q_CHK;
					end
				end
				ST_Q_CHK: begin
					if (rd_eq) begin
						// Start or continue a run of entries equal to the query angle.
						if (!scan_eq_q) begin
							first_lift_q  <= rd_entry.lift;
							run_at_zero_q <= (idx_q == '0);
						end
						scan_eq_q    <= 1'b1;
						prev_angle_q <= rd_entry.angle;
						prev_lift_q  <= rd_entry.lift;
						idx_q        <= idx_p1;
						state_q      <= ST_Q_RD;
					end else if (!rd_gt) begin
						prev_angle_q <= rd_entry.angle;
						prev_lift_q  <= rd_entry.lift;
						idx_q        <= idx_p1;
						state_q      <= ST_Q_RD;
					end else if (scan_eq_q) begin
						// An interior run yields its first lift, a run at the bottom its last.
						res_value_q  <= run_at_zero_q ? prev_lift_q : first_lift_q;
						res_status_q <= STATUS_OK;
						state_q      <= ST_OUT;
					end else if (idx_q == '0) begin
						res_value_q  <= NOT_FOUND_LIFT;
						res_status_q <= STATUS_MISS;
						state_q      <= ST_OUT;
					end else begin
						dx_q    <= dx_full[15:0];
						den_q   <= den_full[15:0];
						dl_q    <= dl_full;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= $signed({1'b0, dx_q}) * dl_q;
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					neg_q   <= prod_q[33];
					quo_q   <= prod_mag[31:0];
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= div_take ? div_diff[15:0] : div_shift[15:0];
					quo_q  <= {quo_q[30:0], div_take};
					step_q <= step_q + SW'(1);
					if (step_q == SW'(DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					res_value_q  <= interp_sum[15:0];
					res_status_q <= STATUS_OK;
					state_q      <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'b0, res_status_q, res_value_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The table never holds more entries than it has room for.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// The entry count only ever grows by one, and only at the end of a load.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			(count_q == $past(count_q) + CW'(1)) && (kind_q == KIND_LOAD))
		else $error("entry count changed unexpectedly");

	// Writes stay inside the filled part of the table plus the one new slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(ram_waddr) <= count_q) && (kind_q == KIND_LOAD))
		else $error("table write outside the filled range");

	// The divider always sees a positive angle span.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (den_q != '0))
		else $error("interpolation span is zero");

	// Taking an item closes the input until its result is handed off.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("input accepted while busy");

endmodule

`default_nettype wire
